### hdl/svpd_pkg.sv
`timescale 1ns / 1ps
// svpd_pkg: shared types and fixed-point constants for the SVPWM duty unit.
// No dependencies.
package svpd_pkg;

   localparam int ANGLE_BITS_DEF = 16;

   localparam logic [14:0] SUPPLY_RST = 15'd12000;
   localparam logic [15:0] PERIOD_RST = 16'd1000;

   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [30:0] PI3_Q30   = 31'd1124419809;
   localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
   localparam logic [15:0] UREF_MAX  = 16'd37814;

   // exact reciprocals for operands below 2^31
   localparam logic [31:0] RCP42    = 32'd3272356036;
   localparam int          RCP42_SH = 37;
   localparam logic [31:0] RCP20    = 32'd3435973837;
   localparam int          RCP20_SH = 36;
   localparam logic [31:0] RCP6     = 32'd2863311531;
   localparam int          RCP6_SH  = 34;

   typedef enum logic [2:0] {
      SEC_NONE = 3'd0,
      SEC_1    = 3'd1,
      SEC_2    = 3'd2,
      SEC_3    = 3'd3,
      SEC_4    = 3'd4,
      SEC_5    = 3'd5,
      SEC_6    = 3'd6
   } sector_type;

   // angle info carried beside the magnitude path
   typedef struct packed {
      logic [23:0] frac;   // offset inside the sector, Q24
      sector_type  sector;
   } ang_side_type;

   typedef struct packed {
      logic [15:0] uref;   // normalized magnitude, Q16
      sector_type  sector;
   } mag_side_type;

endpackage

### hdl/svpd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the SVPWM duty unit.
// No dependencies.
interface svpd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] volt_q;
   logic signed [15:0] volt_d;
   logic        [15:0] elec_angle;

   modport source (output valid, volt_q, volt_d, elec_angle, input ready);
   modport sink   (input valid, volt_q, volt_d, elec_angle, output ready);
endinterface

interface svpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] duty_a;
   logic [15:0] duty_b;
   logic [15:0] duty_c;
   logic [2:0]  sector_num;

   modport source (output valid, duty_a, duty_b, duty_c, sector_num, input ready);
   modport sink   (input valid, duty_a, duty_b, duty_c, sector_num, output ready);
endinterface

### hdl/svpd_sqrt.sv
`timescale 1ns / 1ps
// svpd_sqrt: pipelined restoring square root, floor(sqrt(in_sq * 2^32)).
// One result bit per stage. Depends on svpd_pkg.
module svpd_sqrt
   import svpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [31:0]  in_sq,
   input  ang_side_type in_side,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_root,
   output ang_side_type out_side
);

   localparam int DEPTH = 32;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
   } sq_acc_type;

   function automatic sq_acc_type sq_step(input sq_acc_type cur, input logic [1:0] dig);
      logic [35:0] acc;
      logic [35:0] trial;
      sq_acc_type  nxt;
      acc   = {cur.rem, dig};
      trial = {2'b00, cur.root, 2'b01};
      if (acc >= trial) begin
         nxt.rem  = 34'(acc - trial);
         nxt.root = {cur.root[30:0], 1'b1};
      end else begin
         nxt.rem  = acc[33:0];
         nxt.root = {cur.root[30:0], 1'b0};
      end
      return nxt;
   endfunction

   logic [DEPTH-1:0] v_ff;
   logic [DEPTH:0]   rdy;
   sq_acc_type       acc_ff  [DEPTH];
   sq_acc_type       acc_in  [DEPTH];
   logic [31:0]      x_ff    [DEPTH];
   logic [31:0]      x_in    [DEPTH];
   ang_side_type     side_ff [DEPTH];

   always_comb begin
      rdy[DEPTH] = out_ready;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k + 1];
      end
      acc_in[0] = sq_step('0, in_sq[31:30]);
      x_in[0]   = {in_sq[29:0], 2'b00};
      for (int k = 1; k < DEPTH; k++) begin
         acc_in[k] = sq_step(acc_ff[k - 1], x_ff[k - 1][31:30]);
         x_in[k]   = {x_ff[k - 1][29:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         if (rdy[k]) begin
            acc_ff[k] <= acc_in[k];
            x_ff[k]   <= x_in[k];
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DEPTH-1];
   assign out_root  = acc_ff[DEPTH-1].root;
   assign out_side  = side_ff[DEPTH-1];

endmodule

### hdl/svpd_div.sv
`timescale 1ns / 1ps
// svpd_div: pipelined restoring divide of the root by the supply, clamped to 0.577 Q16.
// One quotient bit per stage. Depends on svpd_pkg.
module svpd_div
   import svpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [14:0]  supply,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [31:0]  in_root,
   input  ang_side_type in_side,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [15:0]  out_uref,
   output ang_side_type out_side
);

   localparam int DEPTH = 17;

   typedef struct packed {
      logic        sat;
      logic [31:0] rem;
      logic [16:0] quo;
   } dv_acc_type;

   function automatic dv_acc_type dv_step(input dv_acc_type cur, input logic [14:0] vm,
                                          input int bit_pos);
      logic [31:0] dsh;
      dv_acc_type  nxt;
      dsh = 32'(vm) << bit_pos;
      nxt = cur;
      if (cur.rem >= dsh) begin
         nxt.rem = cur.rem - dsh;
         nxt.quo = cur.quo | (17'd1 << bit_pos);
      end
      return nxt;
   endfunction

   logic [14:0]      vm;
   logic [DEPTH-1:0] v_ff;
   logic [DEPTH:0]   rdy;
   dv_acc_type       acc_ff  [DEPTH];
   dv_acc_type       acc_in  [DEPTH];
   dv_acc_type       first;
   ang_side_type     side_ff [DEPTH];

   // a zero supply acts as one
   assign vm = (supply == '0) ? 15'd1 : supply;

   always_comb begin
      rdy[DEPTH] = out_ready;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k + 1];
      end
      first.sat = (in_root >= {vm, 17'd0});
      first.rem = in_root;
      first.quo = '0;
      acc_in[0] = dv_step(first, vm, DEPTH - 1);
      for (int k = 1; k < DEPTH; k++) begin
         acc_in[k] = dv_step(acc_ff[k - 1], vm, DEPTH - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         if (rdy[k]) begin
            acc_ff[k]  <= acc_in[k];
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DEPTH-1];
   assign out_side  = side_ff[DEPTH-1];
   assign out_uref  = (acc_ff[DEPTH-1].sat || acc_ff[DEPTH-1].quo > {1'b0, UREF_MAX})
                      ? UREF_MAX : acc_ff[DEPTH-1].quo[15:0];

endmodule

### hdl/svpd_sin.sv
`timescale 1ns / 1ps
// svpd_sin: two-lane pipelined sin(pi/3 * x) polynomial, lanes x = 1 - t and x = t.
// Depends on svpd_pkg.
module svpd_sin
   import svpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [23:0]  in_frac,
   input  mag_side_type in_side,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [30:0]  out_sin_t1,
   output logic [30:0]  out_sin_t2,
   output mag_side_type out_side
);

   localparam int DEPTH = 8;
   localparam int LANES = 2;

   logic [DEPTH-1:0] v_ff;
   logic [DEPTH:0]   rdy;
   logic [30:0]      y_ff   [DEPTH][LANES];
   logic [30:0]      y_in   [DEPTH][LANES];
   logic [30:0]      y2_ff  [DEPTH][LANES];
   logic [30:0]      y2_in  [DEPTH][LANES];
   logic [30:0]      w_ff   [DEPTH][LANES];
   logic [30:0]      w_in   [DEPTH][LANES];
   logic [62:0]      pr_ff  [DEPTH][LANES];
   logic [62:0]      pr_in  [DEPTH][LANES];
   mag_side_type     side_ff [DEPTH];

   always_comb begin
      logic [24:0] xin;
      logic [55:0] prod_y;
      logic [61:0] sq;
      logic [30:0] p;
      rdy[DEPTH] = out_ready;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k + 1];
      end
      for (int l = 0; l < LANES; l++) begin
         // lane 0 feeds T1, lane 1 feeds T2
         xin = (l == 0) ? (25'h100_0000 - {1'b0, in_frac}) : {1'b0, in_frac};
         prod_y = 56'(xin) * 56'(PI3_Q30);
         y_in[0][l]  = prod_y[54:24];
         y2_in[0][l] = '0;
         w_in[0][l]  = '0;
         pr_in[0][l] = '0;
         for (int k = 1; k < DEPTH; k++) begin
            y_in[k][l]  = y_ff[k - 1][l];
            y2_in[k][l] = y2_ff[k - 1][l];
            w_in[k][l]  = w_ff[k - 1][l];
            pr_in[k][l] = pr_ff[k - 1][l];
         end
         sq = 62'(y_ff[0][l]) * 62'(y_ff[0][l]);
         y2_in[1][l] = sq[60:30];
         pr_in[2][l] = 63'(y2_ff[1][l]) * 63'(RCP42);
         p = Q30_ONE - 31'(pr_ff[2][l] >> RCP42_SH);
         sq = 62'(y2_ff[2][l]) * 62'(p);
         w_in[3][l] = sq[60:30];
         pr_in[4][l] = 63'(w_ff[3][l]) * 63'(RCP20);
         p = Q30_ONE - 31'(pr_ff[4][l] >> RCP20_SH);
         sq = 62'(y2_ff[4][l]) * 62'(p);
         w_in[5][l] = sq[60:30];
         pr_in[6][l] = 63'(w_ff[5][l]) * 63'(RCP6);
         p = Q30_ONE - 31'(pr_ff[6][l] >> RCP6_SH);
         sq = 62'(y_ff[6][l]) * 62'(p);
         w_in[7][l] = sq[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         if (rdy[k]) begin
            for (int l = 0; l < LANES; l++) begin
               y_ff[k][l]  <= y_in[k][l];
               y2_ff[k][l] <= y2_in[k][l];
               w_ff[k][l]  <= w_in[k][l];
               pr_ff[k][l] <= pr_in[k][l];
            end
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = v_ff[DEPTH-1];
   assign out_sin_t1 = w_ff[DEPTH-1][0];
   assign out_sin_t2 = w_ff[DEPTH-1][1];
   assign out_side   = side_ff[DEPTH-1];

endmodule

### hdl/svpd_duty.sv
`timescale 1ns / 1ps
// svpd_duty: dwell times, per-sector phase times and compare counts, 4 stages.
// Depends on svpd_pkg.
module svpd_duty
   import svpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [15:0]  period,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [30:0]  in_sin_t1,
   input  logic [30:0]  in_sin_t2,
   input  mag_side_type in_side,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [15:0]  out_duty_a,
   output logic [15:0]  out_duty_b,
   output logic [15:0]  out_duty_c,
   output sector_type   out_sector
);

   localparam int DEPTH = 4;

   logic [DEPTH-1:0] v_ff;
   logic [DEPTH:0]   rdy;

   // stage 0
   logic [29:0] m_ff, m_in;
   logic [30:0] s1_ff, s2_ff;
   sector_type  sec0_ff;
   // stage 1
   logic [30:0] t1_ff, t1_in, t2_ff, t2_in;
   sector_type  sec1_ff;
   // stage 2
   logic [31:0] ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in;
   sector_type  sec2_ff, sec2_in;
   // stage 3
   logic [15:0] da_ff, da_in, db_ff, db_in, dc_ff, dc_in;
   sector_type  sec3_ff;

   always_comb begin
      logic [46:0] pm;
      logic [60:0] p1, p2;
      logic [31:0] sum, t0, h, full, th1, th2;
      logic [47:0] pa, pb, pc;
      rdy[DEPTH] = out_ready;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k + 1];
      end

      pm   = 47'(in_side.uref) * 47'(SQRT3_Q30);
      m_in = pm[45:16];

      p1    = 61'(m_ff) * 61'(s1_ff);
      p2    = 61'(m_ff) * 61'(s2_ff);
      t1_in = p1[60:30];
      t2_in = p2[60:30];

      sum  = 32'(t1_ff) + 32'(t2_ff);
      t0   = (sum >= 32'(Q30_ONE)) ? '0 : 32'(Q30_ONE) - sum;
      h    = t0 >> 1;
      full = sum + h;
      th1  = 32'(t1_ff) + h;
      th2  = 32'(t2_ff) + h;
      sec2_in = sec1_ff;
      unique case (sec1_ff)
         SEC_1: begin ta_in = full; tb_in = th2;  tc_in = h;    end
         SEC_2: begin ta_in = th1;  tb_in = full; tc_in = h;    end
         SEC_3: begin ta_in = h;    tb_in = full; tc_in = th2;  end
         SEC_4: begin ta_in = h;    tb_in = th1;  tc_in = full; end
         SEC_5: begin ta_in = th2;  tb_in = h;    tc_in = full; end
         SEC_6: begin ta_in = full; tb_in = h;    tc_in = th1;  end
         default: begin
            ta_in = '0;
            tb_in = '0;
            tc_in = '0;
            sec2_in = SEC_NONE;
         end
      endcase

      pa = 48'(ta_ff) * 48'(period);
      pb = 48'(tb_ff) * 48'(period);
      pc = 48'(tc_ff) * 48'(period);
      da_in = pa[45:30];
      db_in = pb[45:30];
      dc_in = pc[45:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         m_ff    <= m_in;
         s1_ff   <= in_sin_t1;
         s2_ff   <= in_sin_t2;
         sec0_ff <= in_side.sector;
      end
      if (rdy[1]) begin
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         sec1_ff <= sec0_ff;
      end
      if (rdy[2]) begin
         ta_ff   <= ta_in;
         tb_ff   <= tb_in;
         tc_ff   <= tc_in;
         sec2_ff <= sec2_in;
      end
      if (rdy[3]) begin
         da_ff   <= da_in;
         db_ff   <= db_in;
         dc_ff   <= dc_in;
         sec3_ff <= sec2_ff;
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = v_ff[DEPTH-1];
   assign out_duty_a = da_ff;
   assign out_duty_b = db_ff;
   assign out_duty_c = dc_ff;
   assign out_sector = sec3_ff;

endmodule

### hdl/svpwm_inverse_park_duty_unit.sv
`timescale 1ns / 1ps
// svpwm_inverse_park_duty_unit: SVPWM duty generator with inverse Park magnitude.
// Depends on svpd_pkg, svpd_if, svpd_sqrt, svpd_div, svpd_sin, svpd_duty.
//
//   port   | dir | what moves                                   | handshake
//   -------+-----+----------------------------------------------+-----------------
//   req    | in  | volt_q, volt_d, elec_angle                   | valid/ready
//   rsp    | out | duty_a, duty_b, duty_c, sector_num           | valid/ready
//   APB    | in  | supply_voltage @0x0, pwm_period @0x4         | psel/penable
//
// One transfer per cycle while rsp is ready; the pipe has 1 front stage, 32 root,
// 17 divide, 8 sine and 4 duty stages, a depth set by the bit-per-stage root and divide pipes.
// Synchronous active-high reset clears all valid bits; the registers return to
// 12000 mV and 1000 counts. Each stage holds only while it is full and the stage after
// it is stalled, so bubbles are squeezed out and a stalled rsp loses nothing.
// Config writes are meant for an empty pipe.
module svpwm_inverse_park_duty_unit
   import svpd_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   svpd_req_if.sink          req,
   svpd_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam logic REG_SUPPLY = 1'b0;
   localparam logic REG_PERIOD = 1'b1;

   localparam int ANG_SH = 24 - ANGLE_BITS;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   // ---------------- config registers ----------------
   logic [14:0] supply_ff;
   logic [15:0] period_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RST;
         period_ff <= PERIOD_RST;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_SUPPLY: supply_ff <= pwdata[14:0];
            REG_PERIOD: period_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_SUPPLY: prdata = {17'd0, supply_ff};
         REG_PERIOD: prdata = {16'd0, period_ff};
         default:    prdata = '0;
      endcase
   end

   // ---------------- front stage: squares and sector ----------------
   logic [15:0]            q_abs, d_abs;
   logic                   q_pos;
   logic [31:0]            sumsq;
   logic [23:0]            ang_ext;
   logic [ANGLE_BITS-1:0]  ang_a, theta;
   logic [ANGLE_BITS+2:0]  theta6;
   ang_side_type           front_side;

   logic         f_v_ff;
   logic         f_rdy;
   logic [31:0]  sumsq_ff;
   ang_side_type fside_ff;

   assign q_abs = req.volt_q[15] ? 16'(-req.volt_q) : 16'(req.volt_q);
   assign d_abs = req.volt_d[15] ? 16'(-req.volt_d) : 16'(req.volt_d);
   assign q_pos = !req.volt_q[15] && (req.volt_q != '0);
   assign sumsq = 32'(q_abs) * 32'(q_abs) + 32'(d_abs) * 32'(d_abs);

   // quarter turn ahead for positive q, behind otherwise
   assign ang_ext = {req.elec_angle, 8'h00};
   assign ang_a   = ANGLE_BITS'(ang_ext >> ANG_SH);
   assign theta   = q_pos ? ang_a + QUARTER : ang_a - QUARTER;
   assign theta6  = ({3'b000, theta} << 2) + ({3'b000, theta} << 1);

   assign front_side.frac   = 24'(theta6[ANGLE_BITS-1:0]) << ANG_SH;
   assign front_side.sector = sector_type'(theta6[ANGLE_BITS+2:ANGLE_BITS] + 3'd1);

   logic         sq_in_ready;
   logic         sq_out_valid, dv_in_ready;
   logic [31:0]  sq_root;
   ang_side_type sq_side;
   logic         dv_out_valid, sn_in_ready;
   logic [15:0]  dv_uref;
   ang_side_type dv_side;
   mag_side_type sn_in_side;
   logic         sn_out_valid, dt_in_ready;
   logic [30:0]  sn_t1, sn_t2;
   mag_side_type sn_side;
   sector_type   dt_sector;

   assign f_rdy     = !f_v_ff || sq_in_ready;
   assign req.ready = f_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (f_rdy) begin
         f_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (f_rdy) begin
         sumsq_ff <= sumsq;
         fside_ff <= front_side;
      end
   end

   // ---------------- magnitude: root then divide ----------------
   svpd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_v_ff),
      .in_ready  (sq_in_ready),
      .in_sq     (sumsq_ff),
      .in_side   (fside_ff),
      .out_valid (sq_out_valid),
      .out_ready (dv_in_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   svpd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .supply    (supply_ff),
      .in_valid  (sq_out_valid),
      .in_ready  (dv_in_ready),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_out_valid),
      .out_ready (sn_in_ready),
      .out_uref  (dv_uref),
      .out_side  (dv_side)
   );

   // ---------------- sector sines ----------------
   assign sn_in_side.uref   = dv_uref;
   assign sn_in_side.sector = dv_side.sector;

   svpd_sin u_sin (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_out_valid),
      .in_ready   (sn_in_ready),
      .in_frac    (dv_side.frac),
      .in_side    (sn_in_side),
      .out_valid  (sn_out_valid),
      .out_ready  (dt_in_ready),
      .out_sin_t1 (sn_t1),
      .out_sin_t2 (sn_t2),
      .out_side   (sn_side)
   );

   // ---------------- dwell times and compare counts ----------------
   svpd_duty u_duty (
      .clock      (clock),
      .reset      (reset),
      .period     (period_ff),
      .in_valid   (sn_out_valid),
      .in_ready   (dt_in_ready),
      .in_sin_t1  (sn_t1),
      .in_sin_t2  (sn_t2),
      .in_side    (sn_side),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_duty_a (rsp.duty_a),
      .out_duty_b (rsp.duty_b),
      .out_duty_c (rsp.duty_c),
      .out_sector (dt_sector)
   );

   assign rsp.sector_num = dt_sector;

endmodule
